/* rtl/lfht_pkg.sv */
// Package for the lowest-free handle table: sizes, field widths, codes and
// the shared scan-unit control types. No dependencies.
package lfht_pkg;

    localparam int TABLE_SIZE   = 64;
    localparam int HANDLE_WIDTH = 16;

    // Fixed field widths of the channels and the register.
    localparam int KIND_W     = 3;
    localparam int IDX_W      = 7;
    localparam int HANDLE_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 6;
    localparam int LIMIT_W    = 7;

    // Derived sizes.
    localparam int SLOT_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CNT_W  = $clog2(TABLE_SIZE + 1);

    localparam logic [HANDLE_W-1:0] HANDLE_MASK = (HANDLE_WIDTH >= HANDLE_W) ? '1 :
        HANDLE_W'((64'd1 << HANDLE_WIDTH) - 64'd1);

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_SLOT_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RST = LIMIT_W'(64);

    typedef enum logic [KIND_W-1:0] {
        K_ALLOC  = 3'd0,
        K_FREE   = 3'd1,
        K_LOOKUP = 3'd2,
        K_GETF   = 3'd3,
        K_SETF   = 3'd4,
        K_SWEEP  = 3'd5
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVAL   = 2'd1,
        ST_TOOMANY = 2'd2,
        ST_BADSLOT = 2'd3
    } t_status;

    typedef struct packed {
        logic             load;
        logic             step;
        logic [CNT_W-1:0] start;
        logic [CNT_W-1:0] bound;
    } t_scan_ctl;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic              done;
    } t_scan_sts;

endpackage

/* rtl/lfht_req_if.sv */
// Request channel of the handle table: valid/ready plus the item fields.
// Depends on lfht_pkg.
interface lfht_req_if;
    import lfht_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [IDX_W-1:0]    slot_index;
    logic [HANDLE_W-1:0] handle;
    logic                exec_close_flag;

    modport source (output valid, kind, slot_index, handle, exec_close_flag, input ready);
    modport sink   (input valid, kind, slot_index, handle, exec_close_flag, output ready);
endinterface

/* rtl/lfht_rsp_if.sv */
// Result channel of the handle table: valid/ready plus the result fields.
// Depends on lfht_pkg.
interface lfht_rsp_if;
    import lfht_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot_out;
    logic [HANDLE_W-1:0]   handle_out;
    logic                  flag_out;
    logic                  last;

    modport source (output valid, status, slot_out, handle_out, flag_out, last, input ready);
    modport sink   (input valid, status, slot_out, handle_out, flag_out, last, output ready);
endinterface

/* rtl/lowest_free_handle_table.sv */
// Top level of the lowest-free handle table: sequencer, bitmaps, open count
// and output register. Depends on lfht_pkg, lfht_req_if, lfht_rsp_if,
// lfht_ram, lfht_scan and lfht_apb.
//
//   channel   direction  handshake              carries
//   i_req     in         valid/ready            kind, slot_index, handle, exec_close_flag
//   o_rsp     out        valid/ready            status, slot_out, handle_out, flag_out, last
//   apb       in         psel/penable, pready   slot_limit register at byte address 0
//
// Free, lookup, get-flag, set-flag, unknown kinds and allocates rejected on
// their arguments or on the open count run so: the accept cycle starts the
// registered read of the handle store, and S_EXEC then decides and loads
// the output register.
// An allocate that reaches the scan has the shared scan unit test one slot
// per cycle from the start index upward until it finds a free slot; with no
// free slot below the limit it answers with a too-many status.
// A sweep with nothing marked walks every slot.
// Otherwise it stops after the highest marked slot, with one store read
// (S_SWRD) added for each freed slot.
// A stalled result adds its wait to each of these sequences.
// Reset is synchronous and clears the bitmaps, the open count and the output
// valid; the handle store needs no clearing since every read is guarded by
// the used bit. A stalled result holds the sequencer in place; i_req.ready
// is high whenever the sequencer is idle, even while a result waits.
module lowest_free_handle_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lfht_req_if.sink                     i_req,
    lfht_rsp_if.source                   o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lfht_pkg::PADDR_W-1:0] paddr,
    input  logic [lfht_pkg::PDATA_W-1:0] pwdata,
    output logic [lfht_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import lfht_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_SWEEP = 5'b01000,
        S_SWRD  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Latched item.
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [HANDLE_W-1:0] r_hnd, n_hnd;
    logic                r_flag, n_flag;

    // Table state.
    logic [TABLE_SIZE-1:0] r_used, n_used;
    logic [TABLE_SIZE-1:0] r_exec, n_exec;
    logic [TABLE_SIZE-1:0] r_marked, n_marked;
    logic [CNT_W-1:0]      r_count, n_count;

    // Output register.
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [SLOT_OUT_W-1:0] r_out_slot;
    logic [HANDLE_W-1:0]   r_out_handle;
    logic                  r_out_flag;
    logic                  r_out_last;

    // Result being loaded this cycle.
    logic                  emit;
    t_status               e_status;
    logic [SLOT_OUT_W-1:0] e_slot;
    logic [HANDLE_W-1:0]   e_handle;
    logic                  e_flag;
    logic                  e_last;

    // Store access.
    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    logic                ram_re;
    logic [SLOT_W-1:0]   ram_raddr;
    logic [HANDLE_W-1:0] ram_rdata;

    // Scan unit.
    t_scan_ctl             scan_ctl;
    t_scan_sts             scan_sts;
    logic [TABLE_SIZE-1:0] scan_vec;

    logic [LIMIT_W-1:0]    slot_limit;
    logic [LIMIT_W-1:0]    lim;
    logic                  idx_in_range;
    logic [SLOT_W-1:0]     idx_slot;
    logic                  slot_used;
    logic                  out_free;
    logic                  accept;
    logic [TABLE_SIZE-1:0] marked_rest;

    lfht_apb u_apb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_slot_limit (slot_limit)
    );

    lfht_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (TABLE_SIZE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_hnd),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lfht_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_vec   (scan_vec),
        .o_sts   (scan_sts)
    );

    // The effective limit saturates at the table size.
    assign lim = (slot_limit < LIMIT_W'(TABLE_SIZE)) ? slot_limit : LIMIT_W'(TABLE_SIZE);

    assign idx_in_range = (r_idx < IDX_W'(TABLE_SIZE));
    assign idx_slot     = r_idx[SLOT_W-1:0];
    assign slot_used    = idx_in_range && r_used[idx_slot];
    assign out_free     = !r_out_valid || o_rsp.ready;
    assign i_req.ready  = (r_state == S_IDLE);
    assign accept       = i_req.valid && i_req.ready;

    // Allocate looks for free slots; the sweep looks for marked ones.
    assign scan_vec    = (r_state == S_SCAN) ? ~r_used : r_marked;
    assign marked_rest = r_marked & ~(TABLE_SIZE'(1) << scan_sts.slot);

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_idx     = r_idx;
        n_hnd     = r_hnd;
        n_flag    = r_flag;
        n_used    = r_used;
        n_exec    = r_exec;
        n_marked  = r_marked;
        n_count   = r_count;
        emit      = 1'b0;
        e_status  = ST_OK;
        e_slot    = '0;
        e_handle  = '0;
        e_flag    = 1'b0;
        e_last    = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = scan_sts.slot;
        ram_re    = 1'b0;
        ram_raddr = scan_sts.slot;
        scan_ctl  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind    = i_req.kind;
                    n_idx     = i_req.slot_index;
                    n_hnd     = i_req.handle & HANDLE_MASK;
                    n_flag    = i_req.exec_close_flag;
                    // Start the store read now so the handle is ready next cycle.
                    ram_re    = 1'b1;
                    ram_raddr = i_req.slot_index[SLOT_W-1:0];
                    n_state   = S_EXEC;
                end
            end

            S_EXEC: begin
                unique case (t_kind'(r_kind))
                    K_ALLOC: begin
                        if (!idx_in_range || r_hnd == '0) begin
                            if (out_free) begin
                                emit     = 1'b1;
                                e_status = ST_INVAL;
                                n_state  = S_IDLE;
                            end
                        end else if (r_count >= CNT_W'(lim)) begin
                            if (out_free) begin
                                emit     = 1'b1;
                                e_status = ST_TOOMANY;
                                n_state  = S_IDLE;
                            end
                        end else begin
                            scan_ctl.load  = 1'b1;
                            scan_ctl.start = CNT_W'(r_idx);
                            scan_ctl.bound = CNT_W'(lim);
                            n_state        = S_SCAN;
                        end
                    end
                    K_FREE: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                            if (!slot_used) begin
                                e_status = ST_BADSLOT;
                            end else begin
                                e_slot           = SLOT_OUT_W'(idx_slot);
                                e_handle         = ram_rdata;
                                n_used[idx_slot] = 1'b0;
                                n_exec[idx_slot] = 1'b0;
                                n_count = (r_count == '0) ? '0 : CNT_W'(r_count - 1'b1);
                            end
                        end
                    end
                    K_LOOKUP: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                            if (!slot_used) begin
                                e_status = ST_BADSLOT;
                            end else begin
                                e_handle = ram_rdata;
                            end
                        end
                    end
                    K_GETF: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                            if (!slot_used) begin
                                e_status = ST_BADSLOT;
                            end else begin
                                e_flag = r_exec[idx_slot];
                            end
                        end
                    end
                    K_SETF: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                            if (!slot_used) begin
                                e_status = ST_BADSLOT;
                            end else begin
                                n_exec[idx_slot] = r_flag;
                            end
                        end
                    end
                    K_SWEEP: begin
                        // Snapshot the marked slots and drop every flag at once.
                        n_marked       = r_exec & r_used;
                        n_exec         = '0;
                        scan_ctl.load  = 1'b1;
                        scan_ctl.start = '0;
                        scan_ctl.bound = CNT_W'(TABLE_SIZE);
                        n_state        = S_SWEEP;
                    end
                    default: begin
                        if (out_free) begin
                            emit     = 1'b1;
                            e_status = ST_INVAL;
                            n_state  = S_IDLE;
                        end
                    end
                endcase
            end

            S_SCAN: begin
                if (scan_sts.done) begin
                    if (out_free) begin
                        emit     = 1'b1;
                        e_status = ST_TOOMANY;
                        n_state  = S_IDLE;
                    end
                end else if (scan_sts.hit) begin
                    if (out_free) begin
                        ram_we                = 1'b1;
                        n_used[scan_sts.slot] = 1'b1;
                        n_exec[scan_sts.slot] = 1'b0;
                        n_count               = CNT_W'(r_count + 1'b1);
                        emit                  = 1'b1;
                        e_slot                = SLOT_OUT_W'(scan_sts.slot);
                        n_state               = S_IDLE;
                    end
                end else begin
                    scan_ctl.step = 1'b1;
                end
            end

            S_SWEEP: begin
                if (scan_sts.done) begin
                    // Only reached when nothing was marked: one empty result.
                    if (out_free) begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (scan_sts.hit) begin
                    ram_re  = 1'b1;
                    n_state = S_SWRD;
                end else begin
                    scan_ctl.step = 1'b1;
                end
            end

            S_SWRD: begin
                if (out_free) begin
                    emit                  = 1'b1;
                    e_slot                = SLOT_OUT_W'(scan_sts.slot);
                    e_handle              = ram_rdata;
                    e_last                = (marked_rest == '0);
                    n_marked              = marked_rest;
                    n_used[scan_sts.slot] = 1'b0;
                    n_count = (r_count == '0) ? '0 : CNT_W'(r_count - 1'b1);
                    if (marked_rest == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        scan_ctl.step = 1'b1;
                        n_state       = S_SWEEP;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_exec      <= '0;
            r_marked    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_exec   <= n_exec;
            r_marked <= n_marked;
            r_count  <= n_count;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and result payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_idx  <= n_idx;
        r_hnd  <= n_hnd;
        r_flag <= n_flag;
        if (emit) begin
            r_out_status <= e_status;
            r_out_slot   <= e_slot;
            r_out_handle <= e_handle;
            r_out_flag   <= e_flag;
            r_out_last   <= e_last;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.slot_out   = r_out_slot;
    assign o_rsp.handle_out = r_out_handle;
    assign o_rsp.flag_out   = r_out_flag;
    assign o_rsp.last       = r_out_last;
endmodule

/* rtl/lfht_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lfht_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/lfht_apb.sv */
// Configuration register file of the handle table (slot_limit) behind an
// APB-style port. Depends on lfht_pkg.
module lfht_apb (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lfht_pkg::PADDR_W-1:0]        paddr,
    input  logic [lfht_pkg::PDATA_W-1:0]        pwdata,
    output logic [lfht_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    output logic [lfht_pkg::LIMIT_W-1:0]        o_slot_limit
);
    import lfht_pkg::*;

    logic [LIMIT_W-1:0] r_slot_limit;
    logic               hit_limit;

    // The register index is the byte address divided by four.
    assign hit_limit = (paddr[PADDR_W-1] == REG_SLOT_LIMIT);
    assign pready    = 1'b1;
    assign prdata    = hit_limit ? PDATA_W'(r_slot_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_limit <= SLOT_LIMIT_RST;
        end else if (psel && penable && pwrite && pready && hit_limit) begin
            r_slot_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    assign o_slot_limit = r_slot_limit;
endmodule

/* rtl/lfht_scan.sv */
// Shared slot scan unit: a slot counter with a bound compare and a bit test,
// stepped by the sequencer for allocate and sweep. Depends on lfht_pkg.
module lfht_scan (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lfht_pkg::t_scan_ctl             i_ctl,
    input  logic [lfht_pkg::TABLE_SIZE-1:0] i_vec,
    output lfht_pkg::t_scan_sts             o_sts
);
    import lfht_pkg::*;

    logic [CNT_W-1:0] r_slot;
    logic [CNT_W-1:0] r_bound;
    logic             done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_bound <= '0;
        end else if (i_ctl.load) begin
            r_slot  <= i_ctl.start;
            r_bound <= i_ctl.bound;
        end else if (i_ctl.step) begin
            r_slot  <= CNT_W'(r_slot + 1'b1);
        end
    end

    assign done       = (r_slot >= r_bound);
    assign o_sts.done = done;
    assign o_sts.slot = r_slot[SLOT_W-1:0];
    assign o_sts.hit  = !done && i_vec[r_slot[SLOT_W-1:0]];
endmodule

/* rtl/lfht_checker.sv */
// Port-level checker for the handle table and its bind to the top level.
// Depends on lfht_pkg and lowest_free_handle_table.
module lfht_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_req_valid,
    input logic                                i_req_ready,
    input logic                                i_rsp_valid,
    input logic                                i_rsp_ready,
    input logic [lfht_pkg::STATUS_W-1:0]       i_rsp_status,
    input logic [lfht_pkg::SLOT_OUT_W-1:0]     i_rsp_slot_out,
    input logic [lfht_pkg::HANDLE_W-1:0]       i_rsp_handle_out,
    input logic                                i_rsp_flag_out,
    input logic                                i_rsp_last
);
    import lfht_pkg::*;

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

    // A stalled result keeps its payload.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_slot_out) && $stable(i_rsp_handle_out)
            && $stable(i_rsp_flag_out) && $stable(i_rsp_last))
        else $error("stalled result changed");

    // Every item passes through the execute state before the next is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("item accepted in back-to-back cycles");

    // A failed item gives a single result with every other field zero.
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != ST_OK |-> i_rsp_last && i_rsp_slot_out == '0
            && i_rsp_handle_out == '0 && !i_rsp_flag_out)
        else $error("error result carries data");
endmodule

bind lowest_free_handle_table lfht_checker u_lfht_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_status     (o_rsp.status),
    .i_rsp_slot_out   (o_rsp.slot_out),
    .i_rsp_handle_out (o_rsp.handle_out),
    .i_rsp_flag_out   (o_rsp.flag_out),
    .i_rsp_last       (o_rsp.last)
);

/* tb/tb_lowest_free_handle_table.sv */
// Self-checking testbench for lowest_free_handle_table: drives requests, the
// slot limit register and result back-pressure, and checks every result.
// Depends on lfht_pkg, lfht_req_if, lfht_rsp_if and the table RTL.
module tb_lowest_free_handle_table;
    timeunit 1ns;
    timeprecision 1ps;

    import lfht_pkg::*;

    // Kind codes the block does not define; both must come back as invalid.
    localparam logic [KIND_W-1:0] KIND_UNUSED_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED_B = 3'd7;

    localparam logic [PADDR_W-1:0] SLOT_LIMIT_ADDR = PADDR_W'(4 * REG_SLOT_LIMIT);

    // A sweep walks the slots and reads the store once per freed slot; this
    // margin is sized to cover that, the longest busy stretch.
    localparam int DRAIN_CYCLES  = 3 + 2 * TABLE_SIZE;
    // Length of the forced result stall used to fill the block.
    localparam int HOLD_CYCLES   = 400;
    // Cycles without any handshake before the run is declared hung. This is
    // several times the forced stall plus the slowest sweep.
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 55;

    // One result item as the checker sees it.
    typedef struct packed {
        t_status                status;
        logic [SLOT_OUT_W-1:0]  slot;
        logic [HANDLE_W-1:0]    handle;
        logic                   flag;
        logic                   last;
    } t_table_result;

    // Shadow copy of the handle table. Every accepted request is applied to
    // the shadow state, and the results it must produce are queued in order.
    class table_shadow;
        logic [HANDLE_W-1:0]   handles [TABLE_SIZE];
        logic [TABLE_SIZE-1:0] used_map;
        logic [TABLE_SIZE-1:0] cloexec_map;
        int unsigned           open_cnt;
        logic [LIMIT_W-1:0]    limit_reg;
        t_table_result         due_results [$];
        int unsigned           errors;

        function new();
            used_map    = '0;
            cloexec_map = '0;
            open_cnt    = 0;
            limit_reg   = SLOT_LIMIT_RST;
            errors      = 0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] value);
            limit_reg = value;
        endfunction

        function void push(t_status st, int slot, logic [HANDLE_W-1:0] hnd,
                           logic flag, logic last);
            t_table_result r;
            r.status = st;
            r.slot   = SLOT_OUT_W'(slot);
            r.handle = hnd;
            r.flag   = flag;
            r.last   = last;
            due_results.push_back(r);
        endfunction

        function bit slot_live(logic [IDX_W-1:0] idx);
            return idx < TABLE_SIZE && used_map[idx[SLOT_W-1:0]];
        endfunction

        function void free_slot(int s);
            used_map[s]    = 1'b0;
            cloexec_map[s] = 1'b0;
            if (open_cnt > 0) open_cnt--;
        endfunction

        // Applies one accepted request and queues the results it causes.
        function void note_request(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
                                   logic [HANDLE_W-1:0] hnd_in, logic flag);
            logic [HANDLE_W-1:0]   hnd;
            logic [TABLE_SIZE-1:0] marked;
            int                    lim;
            int                    s;
            int                    n;
            hnd = hnd_in & HANDLE_MASK;
            lim = (limit_reg < TABLE_SIZE) ? int'(limit_reg) : TABLE_SIZE;
            case (kind)
                K_ALLOC: begin
                    if (idx >= TABLE_SIZE || hnd == '0) begin
                        push(ST_INVAL, 0, '0, 1'b0, 1'b1);
                    end else if (open_cnt >= lim) begin
                        push(ST_TOOMANY, 0, '0, 1'b0, 1'b1);
                    end else begin
                        s = int'(idx);
                        while (s < lim && used_map[s]) s++;
                        if (s >= lim) begin
                            push(ST_TOOMANY, 0, '0, 1'b0, 1'b1);
                        end else begin
                            used_map[s]    = 1'b1;
                            cloexec_map[s] = 1'b0;
                            handles[s]     = hnd;
                            open_cnt       = (open_cnt + 1) & 7'h7F;
                            push(ST_OK, s, '0, 1'b0, 1'b1);
                        end
                    end
                end
                K_FREE: begin
                    if (!slot_live(idx)) begin
                        push(ST_BADSLOT, 0, '0, 1'b0, 1'b1);
                    end else begin
                        free_slot(int'(idx));
                        push(ST_OK, int'(idx), handles[idx[SLOT_W-1:0]], 1'b0, 1'b1);
                    end
                end
                K_LOOKUP: begin
                    if (!slot_live(idx)) push(ST_BADSLOT, 0, '0, 1'b0, 1'b1);
                    else push(ST_OK, 0, handles[idx[SLOT_W-1:0]], 1'b0, 1'b1);
                end
                K_GETF: begin
                    if (!slot_live(idx)) push(ST_BADSLOT, 0, '0, 1'b0, 1'b1);
                    else push(ST_OK, 0, '0, cloexec_map[idx[SLOT_W-1:0]], 1'b1);
                end
                K_SETF: begin
                    if (!slot_live(idx)) begin
                        push(ST_BADSLOT, 0, '0, 1'b0, 1'b1);
                    end else begin
                        cloexec_map[idx[SLOT_W-1:0]] = flag;
                        push(ST_OK, 0, '0, 1'b0, 1'b1);
                    end
                end
                K_SWEEP: begin
                    marked      = cloexec_map & used_map;
                    cloexec_map = '0;
                    n           = 0;
                    for (int k = 0; k < TABLE_SIZE; k++) begin
                        if (marked[k]) begin
                            free_slot(k);
                            marked[k] = 1'b0;
                            push(ST_OK, k, handles[k], 1'b0, marked == '0);
                            n++;
                        end
                    end
                    // An empty sweep still answers once.
                    if (n == 0) push(ST_OK, 0, '0, 1'b0, 1'b1);
                end
                default: push(ST_INVAL, 0, '0, 1'b0, 1'b1);
            endcase
        endfunction

        // Compares one accepted result with the oldest queued one.
        function void check_result(t_table_result got);
            t_table_result want;
            if (due_results.size() == 0) begin
                $error("result with nothing outstanding: status %0d slot %0d handle %0h",
                       got.status, got.slot, got.handle);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.status != want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.slot != want.slot) begin
                $error("slot_out: expected %0d, got %0d", want.slot, got.slot);
                errors++;
            end
            if (got.handle != want.handle) begin
                $error("handle_out: expected %0h, got %0h", want.handle, got.handle);
                errors++;
            end
            if (got.flag != want.flag) begin
                $error("flag_out: expected %0d, got %0d", want.flag, got.flag);
                errors++;
            end
            if (got.last != want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction

        // Mostly returns a slot that is in use, so single-slot operations
        // reach the success paths instead of bouncing off as bad slots.
        function logic [IDX_W-1:0] pick_used();
            int n;
            int k;
            n = $countones(used_map);
            if (n == 0) return IDX_W'($urandom_range(0, 127));
            k = $urandom_range(0, n - 1);
            for (int s = 0; s < TABLE_SIZE; s++) begin
                if (used_map[s]) begin
                    if (k == 0) return IDX_W'(s);
                    k--;
                end
            end
            return '0;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    lfht_req_if req ();
    lfht_rsp_if rsp ();

    lowest_free_handle_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    table_shadow shadow = new();

    // Percent chances of an idle sender cycle and of a stalled result cycle.
    int unsigned snd_idle_pct = 0;
    int unsigned rsp_stall_pct = 0;

    // The stimulus asks for a long result stall by bumping holds_asked; the
    // receiver process counts the stall out itself.
    int unsigned holds_asked = 0;
    int unsigned holds_served = 0;
    int unsigned hold_left = 0;

    int unsigned quiet_cycles = 0;

    logic [LIMIT_W-1:0] phase_limits [PHASES];

    always #1 i_clk = ~i_clk;

    // Result back-pressure: held off during reset, random stalls at the
    // current rate afterwards, except while a forced hold is counted out.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp.ready <= 1'b0;
        end else if (hold_left != 0) begin
            rsp.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            rsp.ready    <= 1'b0;
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
        end else begin
            rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // Both handshakes are sampled at the same edge. The result is checked
    // before the request is noted, though a request can never produce a
    // result on its own accept edge anyway.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp.valid && rsp.ready)
                shadow.check_result({t_status'(rsp.status), rsp.slot_out,
                                     rsp.handle_out, rsp.flag_out, rsp.last});
            if (req.valid && req.ready)
                shadow.note_request(req.kind, req.slot_index, req.handle,
                                    req.exec_close_flag);
        end
    end

    // Hang detector: any handshake or register access restarts the count.
    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_lowest_free_handle_table: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one request after a random number of idle cycles and returns on
    // the edge at which it is accepted. valid stays high into the next item
    // when no idle cycle follows.
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [IDX_W-1:0] idx,
                                input logic [HANDLE_W-1:0] hnd,
                                input logic flag);
        while ($urandom_range(99) < snd_idle_pct) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid           <= 1'b1;
        req.kind            <= kind;
        req.slot_index      <= idx;
        req.handle          <= hnd;
        req.exec_close_flag <= flag;
        do @(posedge i_clk); while (!req.ready);
    endtask

    // One random request. Allocates and set-flags dominate so that the
    // table fills and sweeps have marked slots to free; frees and sweeps
    // keep it from staying full. Fields a kind ignores carry random noise.
    task automatic random_request();
        int unsigned         pick;
        logic [KIND_W-1:0]   kind;
        logic [IDX_W-1:0]    idx;
        logic [HANDLE_W-1:0] hnd;
        logic                flag;
        pick = $urandom_range(99);
        hnd  = HANDLE_W'($urandom);
        flag = 1'($urandom_range(1));
        idx  = ($urandom_range(99) < 80) ? shadow.pick_used()
                                         : IDX_W'($urandom_range(0, 127));
        if (pick < 32) begin
            kind = K_ALLOC;
            pick = $urandom_range(99);
            // Low start indexes keep the one-slot-per-cycle scan short.
            if (pick < 70) idx = IDX_W'($urandom_range(0, 15));
            else if (pick < 90) idx = IDX_W'($urandom_range(0, TABLE_SIZE - 1));
            else idx = IDX_W'($urandom_range(0, 127));
            pick = $urandom_range(99);
            if (pick < 5) hnd = '0;
            else if (pick < 10) hnd = '1;
            else hnd = HANDLE_W'($urandom_range(1, 65535));
        end else if (pick < 46) begin
            kind = K_FREE;
        end else if (pick < 58) begin
            kind = K_LOOKUP;
        end else if (pick < 66) begin
            kind = K_GETF;
        end else if (pick < 86) begin
            kind = K_SETF;
            flag = ($urandom_range(99) < 70);
        end else if (pick < 93) begin
            kind = K_SWEEP;
        end else begin
            kind = $urandom_range(1) ? KIND_UNUSED_A : KIND_UNUSED_B;
        end
        send_request(kind, idx, hnd, flag);
    endtask

    // Drops valid, lets the monitor note the last accepted item, waits for
    // every queued result, then lets the sequencer finish any trailing work.
    task automatic wait_drained();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (shadow.due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle held until pready.
    task automatic write_slot_limit(input logic [LIMIT_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SLOT_LIMIT_ADDR;
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow.set_limit(value);
    endtask

    initial begin
        // Every block input starts at a known value; the result ready is
        // held low by its own process while reset is asserted.
        i_rst_n             = 1'b0;
        req.valid           = 1'b0;
        req.kind            = K_ALLOC;
        req.slot_index      = '0;
        req.handle          = '0;
        req.exec_close_flag = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;

        // Limit settings per phase: saturating, zero, one, full table and a
        // few in between, one of them random.
        phase_limits = '{7'd127, 7'd0, 7'd1, 7'd64, 7'd10, 7'd63, 7'd40, 7'd64};
        phase_limits[6] = LIMIT_W'($urandom_range(2, 62));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, at the reset limit with no idling on either side.
        send_request(K_ALLOC, 7'd0, 16'hFFFF, 1'b0);     // lowest slot, all-ones handle
        send_request(K_ALLOC, 7'd0, 16'h0000, 1'b1);     // null handle
        send_request(K_ALLOC, 7'd64, 16'h0001, 1'b0);    // start just past the table
        send_request(K_ALLOC, 7'd127, 16'h0001, 1'b0);   // largest start index
        send_request(K_ALLOC, 7'd63, 16'h0001, 1'b0);    // top slot
        send_request(K_ALLOC, 7'd63, 16'h0007, 1'b0);    // top slot taken: nothing free
        send_request(K_ALLOC, 7'd5, 16'h8000, 1'b0);
        send_request(K_ALLOC, 7'd0, 16'h1234, 1'b0);     // skips slot 0, lands on 1
        send_request(K_LOOKUP, 7'd0, 16'h0000, 1'b0);
        send_request(K_LOOKUP, 7'd2, 16'hFFFF, 1'b1);    // unused slot
        send_request(K_LOOKUP, 7'd127, 16'h0000, 1'b0);  // out of range
        send_request(K_GETF, 7'd0, 16'h0000, 1'b0);
        send_request(K_SETF, 7'd0, 16'h0000, 1'b1);
        send_request(K_GETF, 7'd0, 16'h0000, 1'b0);
        send_request(K_SETF, 7'd63, 16'h0000, 1'b1);
        send_request(K_SETF, 7'd5, 16'h0000, 1'b1);
        send_request(K_SETF, 7'd5, 16'h0000, 1'b0);      // marks and unmarks
        send_request(K_SETF, 7'd100, 16'h0000, 1'b1);    // out of range
        send_request(K_GETF, 7'd64, 16'h0000, 1'b0);     // out of range
        send_request(K_FREE, 7'd1, 16'h0000, 1'b0);
        send_request(K_FREE, 7'd1, 16'h0000, 1'b0);      // double free
        send_request(K_FREE, 7'd127, 16'h0000, 1'b0);
        send_request(KIND_UNUSED_A, 7'd0, 16'hFFFF, 1'b1);
        send_request(KIND_UNUSED_B, 7'd127, 16'hFFFF, 1'b1);
        send_request(K_SWEEP, 7'd0, 16'h0000, 1'b0);     // frees slots 0 and 63
        send_request(K_SWEEP, 7'd0, 16'h0000, 1'b0);     // nothing left marked

        // Random phases. Each starts from an idle block, rewrites the limit
        // and picks one of four idling patterns.
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_slot_limit(phase_limits[p]);
            case (p % 4)
                0: begin snd_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin snd_idle_pct = 67; rsp_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rsp_stall_pct = 67; end
                default: begin snd_idle_pct = 35; rsp_stall_pct = 35; end
            endcase
            // In the first phase the receiver goes away for a long stretch
            // while requests keep coming, so the block fills and stalls.
            if (p == 0) holds_asked <= holds_asked + 1;
            repeat (ITEMS_PER_PHASE) random_request();
        end

        wait_drained();
        if (shadow.errors == 0) begin
            $display("tb_lowest_free_handle_table: done, clean");
        end else begin
            $display("tb_lowest_free_handle_table: done, errors");
        end
        $finish;
    end

endmodule

/* lowest_free_handle_table.f */
rtl/lfht_pkg.sv
rtl/lfht_req_if.sv
rtl/lfht_rsp_if.sv
rtl/lfht_ram.sv
rtl/lfht_apb.sv
rtl/lfht_scan.sv
rtl/lowest_free_handle_table.sv
rtl/lfht_checker.sv
tb/tb_lowest_free_handle_table.sv
